>>> src/scmrd_pkg.sv
`default_nettype none

package scmrd_pkg;

   // Width of the running frame position; it wraps modulo 2**OFFSET_BITS.
   localparam int unsigned OFFSET_BITS = 17;

   localparam int unsigned RUN_OFFSET_W = 17;
   localparam int unsigned RUN_LENGTH_W = 16;
   localparam int unsigned MASK_BYTE_W  = 8;

   // Position widened so that a low 17-bit slice always exists.
   localparam int unsigned POS_EXT_W =
      (OFFSET_BITS > RUN_OFFSET_W) ? OFFSET_BITS : RUN_OFFSET_W;

   localparam logic [MASK_BYTE_W-1:0] CTRL_SKIP_EXT = 8'h80;
   localparam logic [MASK_BYTE_W-1:0] CTRL_COPY_EXT = 8'h00;
   localparam logic [6:0]             SKIP_LEN_MASK = 7'h7F;

   localparam logic KIND_SKIP = 1'b0;
   localparam logic KIND_COPY = 1'b1;

   typedef struct packed {
      logic [MASK_BYTE_W-1:0] mask_byte;
      logic                   end_of_mask;
   } req_type;

   typedef struct packed {
      logic                    run_kind;
      logic [RUN_OFFSET_W-1:0] run_offset;
      logic [RUN_LENGTH_W-1:0] run_length;
      logic                    mask_done;
      logic                    truncated;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/skip_copy_mask_run_decoder.sv
`default_nettype none

// Channel  | Ports                          | Direction | Word
// ---------+--------------------------------+-----------+-----------------------
// request  | req_valid, req_ready, req_data | in        | mask byte, end flag
// response | rsp_valid, rsp_ready, rsp_data | out       | kind, offset, length
//
// Each mask byte is decoded in the cycle it is accepted; its run, if any,
// appears in the response register on the next cycle. One byte per cycle
// while the response side drains. The parser state and the position adder
// form the only loop. The request side stays ready while the response register
// is empty or being drained. Reset is synchronous and returns the parser to
// the control-byte phase at position zero.
module skip_copy_mask_run_decoder (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  scmrd_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output scmrd_pkg::rsp_type   rsp_data
);

   typedef enum logic [1:0] {
      PH_CTRL   = 2'd0,
      PH_LEN_LO = 2'd1,
      PH_LEN_HI = 2'd2
   } phase_type;

   phase_type                                 phase_ff, phase_in;
   logic                                      pending_kind_ff, pending_kind_in;
   logic [scmrd_pkg::MASK_BYTE_W-1:0]         length_low_ff, length_low_in;
   logic [scmrd_pkg::OFFSET_BITS-1:0]         position_ff, position_in;
   logic                                      rsp_valid_ff;
   scmrd_pkg::rsp_type                        rsp_data_ff;

   logic                                      req_fire;
   logic                                      emit;
   scmrd_pkg::rsp_type                        result;
   logic [scmrd_pkg::POS_EXT_W-1:0]           position_ext;
   logic [scmrd_pkg::OFFSET_BITS-1:0]         position_next;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign position_ext = scmrd_pkg::POS_EXT_W'(position_ff);

   always_comb begin
      phase_in        = phase_ff;
      pending_kind_in = pending_kind_ff;
      length_low_in   = length_low_ff;
      emit            = 1'b0;
      result.run_kind   = pending_kind_ff;
      result.run_offset = position_ext[scmrd_pkg::RUN_OFFSET_W-1:0];
      result.run_length = '0;
      result.mask_done  = req_data.end_of_mask;
      result.truncated  = 1'b0;

      case (phase_ff)
         PH_LEN_LO: begin
            length_low_in = req_data.mask_byte;
            phase_in      = PH_LEN_HI;
            if (req_data.end_of_mask) begin
               emit             = 1'b1;
               result.truncated = 1'b1;
            end
         end
         PH_LEN_HI: begin
            emit              = 1'b1;
            result.run_length = {req_data.mask_byte, length_low_ff};
            phase_in          = PH_CTRL;
         end
         default: begin
            // Control byte; the unused phase code is treated the same way.
            phase_in = PH_CTRL;
            if (req_data.mask_byte == scmrd_pkg::CTRL_SKIP_EXT ||
                req_data.mask_byte == scmrd_pkg::CTRL_COPY_EXT) begin
               pending_kind_in = (req_data.mask_byte == scmrd_pkg::CTRL_COPY_EXT) ?
                                 scmrd_pkg::KIND_COPY : scmrd_pkg::KIND_SKIP;
               phase_in        = PH_LEN_LO;
               result.run_kind = pending_kind_in;
               if (req_data.end_of_mask) begin
                  emit             = 1'b1;
                  result.truncated = 1'b1;
               end
            end else if (req_data.mask_byte[7]) begin
               emit              = 1'b1;
               result.run_kind   = scmrd_pkg::KIND_SKIP;
               result.run_length = scmrd_pkg::RUN_LENGTH_W'(
                  req_data.mask_byte[6:0] & scmrd_pkg::SKIP_LEN_MASK);
            end else begin
               emit              = 1'b1;
               result.run_kind   = scmrd_pkg::KIND_COPY;
               result.run_length = scmrd_pkg::RUN_LENGTH_W'(req_data.mask_byte);
            end
         end
      endcase

      position_next = position_ff
                    + scmrd_pkg::OFFSET_BITS'(result.run_length);
      position_in   = emit ? position_next : position_ff;

      // The last byte of a mask returns the parser to its starting point.
      if (req_data.end_of_mask) begin
         phase_in        = PH_CTRL;
         pending_kind_in = 1'b0;
         length_low_in   = '0;
         position_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_CTRL;
         pending_kind_ff <= 1'b0;
         length_low_ff   <= '0;
         position_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff        <= phase_in;
            pending_kind_ff <= pending_kind_in;
            length_low_ff   <= length_low_in;
            position_ff     <= position_in;
            rsp_valid_ff    <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire && emit) begin
         rsp_data_ff <= result;
      end
   end

`ifndef NO_ASSERTIONS
   a_trunc_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.truncated |->
         rsp_data_ff.mask_done && rsp_data_ff.run_length == '0)
      else $error("truncated run without end of mask or with nonzero length");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.end_of_mask |=>
         phase_ff == PH_CTRL && position_ff == '0 && rsp_valid_ff)
      else $error("parser not restarted after last mask byte");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled while response register is empty");

   a_low_byte_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == PH_LEN_LO && !req_data.end_of_mask |=>
         !rsp_valid_ff && phase_ff == PH_LEN_HI)
      else $error("length low byte produced a run");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int RANDOM_WORDS   = 1000;
   localparam int IDLE_PERCENT   = 38;

   typedef enum logic [1:0] {
      PHASE_CONTROL,
      PHASE_LEN_LOW,
      PHASE_LEN_HIGH
   } parse_phase_type;

   class run_scoreboard_type;
      parse_phase_type                      phase;
      logic                                 pending_kind;
      logic [7:0]                           len_low;
      logic [scmrd_pkg::POS_EXT_W-1:0]      position;
      scmrd_pkg::rsp_type                   runs_due[$];
      int                                   mismatches;

      function new();
         phase        = PHASE_CONTROL;
         pending_kind = scmrd_pkg::KIND_SKIP;
         len_low      = '0;
         position     = '0;
         mismatches   = 0;
      endfunction

      function void log_run(logic kind, logic [15:0] len, logic done, logic trunc);
         scmrd_pkg::rsp_type run;
         logic [63:0]        sum;
         run.run_kind   = kind;
         run.run_offset = position[scmrd_pkg::RUN_OFFSET_W-1:0];
         run.run_length = len;
         run.mask_done  = done;
         run.truncated  = trunc;
         runs_due.push_back(run);
         sum      = 64'(position) + 64'(len);
         position = scmrd_pkg::POS_EXT_W'(
            sum & ((64'd1 << scmrd_pkg::OFFSET_BITS) - 64'd1));
      endfunction

      // Advances the parser by one accepted mask word and queues its run, if any.
      function void note_mask_byte(scmrd_pkg::req_type w);
         logic [7:0] b;
         logic       last;
         b    = w.mask_byte;
         last = w.end_of_mask;
         case (phase)
            PHASE_LEN_LOW: begin
               len_low = b;
               phase   = PHASE_LEN_HIGH;
               if (last)
                  log_run(pending_kind, 16'd0, 1'b1, 1'b1);
            end
            PHASE_LEN_HIGH: begin
               log_run(pending_kind, {b, len_low}, last, 1'b0);
               phase = PHASE_CONTROL;
            end
            default: begin
               phase = PHASE_CONTROL;
               if (b == scmrd_pkg::CTRL_SKIP_EXT || b == scmrd_pkg::CTRL_COPY_EXT) begin
                  pending_kind = (b == scmrd_pkg::CTRL_COPY_EXT) ?
                                 scmrd_pkg::KIND_COPY : scmrd_pkg::KIND_SKIP;
                  phase        = PHASE_LEN_LOW;
                  if (last)
                     log_run(pending_kind, 16'd0, 1'b1, 1'b1);
               end else if (b[7]) begin
                  log_run(scmrd_pkg::KIND_SKIP, 16'(b[6:0] & scmrd_pkg::SKIP_LEN_MASK),
                          last, 1'b0);
               end else begin
                  log_run(scmrd_pkg::KIND_COPY, 16'(b), last, 1'b0);
               end
            end
         endcase
         // The end of a mask returns the parser and the position to zero.
         if (last) begin
            phase        = PHASE_CONTROL;
            pending_kind = scmrd_pkg::KIND_SKIP;
            len_low      = '0;
            position     = '0;
         end
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
         mismatches++;
      endtask

      task check_run(scmrd_pkg::rsp_type got);
         scmrd_pkg::rsp_type want;
         if (runs_due.size() == 0) begin
            report("run with none expected", got, 0);
         end else begin
            want = runs_due.pop_front();
            if (got.run_kind !== want.run_kind)
               report("run_kind", got.run_kind, want.run_kind);
            if (got.run_offset !== want.run_offset)
               report("run_offset", got.run_offset, want.run_offset);
            if (got.run_length !== want.run_length)
               report("run_length", got.run_length, want.run_length);
            if (got.mask_done !== want.mask_done)
               report("mask_done", got.mask_done, want.mask_done);
            if (got.truncated !== want.truncated)
               report("truncated", got.truncated, want.truncated);
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   scmrd_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   scmrd_pkg::rsp_type rsp_data;

   run_scoreboard_type board = new();

   bit steady = 1'b0;
   int stall_requests = 0;
   int words_sent = 0;
   int idle_cycles = 0;

   skip_copy_mask_run_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random back-pressure plus one long hold-off on request.
   always @(posedge clock) begin
      static int hold_left = 0;
      static int stalls_served = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_run(rsp_data);
         if (stalls_served != stall_requests) begin
            stalls_served = stall_requests;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task send_byte(logic [7:0] b, logic last);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(99) < IDLE_PERCENT)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mask_byte: b, end_of_mask: last};
      do @(posedge clock); while (!req_ready);
      board.note_mask_byte('{mask_byte: b, end_of_mask: last});
      words_sent++;
   endtask

   task send_mask(logic [7:0] bytes[$]);
      foreach (bytes[i])
         send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // A well-formed mask of random runs, sometimes cut off inside a length field.
   task send_random_mask();
      logic [7:0]  bytes[$];
      logic [15:0] len;
      int          runs;
      runs = ($urandom_range(3) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
      repeat (runs) begin
         len = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 300));
         case ($urandom_range(3))
            0: bytes.push_back({1'b1, 7'($urandom_range(1, 127))});
            1: bytes.push_back({1'b0, 7'($urandom_range(1, 127))});
            2: bytes = {bytes, scmrd_pkg::CTRL_SKIP_EXT, len[7:0], len[15:8]};
            default: bytes = {bytes, scmrd_pkg::CTRL_COPY_EXT, len[7:0], len[15:8]};
         endcase
      end
      if ($urandom_range(7) == 0) begin
         bytes.push_back($urandom_range(1) ? scmrd_pkg::CTRL_SKIP_EXT
                                           : scmrd_pkg::CTRL_COPY_EXT);
         if ($urandom_range(1))
            bytes.push_back(8'($urandom));
      end
      send_mask(bytes);
   endtask

   initial begin
      int mask_count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Short and extended runs at their extremes, a zero-length copy.
      send_mask('{8'h01, 8'h7F, 8'h81, 8'hFF, scmrd_pkg::CTRL_SKIP_EXT, 8'hFF, 8'hFF,
                  scmrd_pkg::CTRL_COPY_EXT, 8'h00, 8'h00});
      // Masks that end inside a length field, and a one-word mask.
      send_mask('{scmrd_pkg::CTRL_SKIP_EXT});
      send_mask('{scmrd_pkg::CTRL_COPY_EXT});
      send_mask('{scmrd_pkg::CTRL_COPY_EXT, 8'h34});
      send_mask('{8'h7F});
      // Three maximal skips carry the position past its wrap point.
      send_mask('{scmrd_pkg::CTRL_SKIP_EXT, 8'hFF, 8'hFF,
                  scmrd_pkg::CTRL_SKIP_EXT, 8'hFF, 8'hFF,
                  scmrd_pkg::CTRL_SKIP_EXT, 8'hFF, 8'hFF, 8'h05});

      mask_count = 0;
      while (words_sent < RANDOM_WORDS + 25) begin
         if (mask_count == 15) steady = 1'b1;
         if (mask_count == 45) steady = 1'b0;
         if (mask_count == 70) stall_requests++;
         if (mask_count == 90) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (board.runs_due.size() != 0);
         end
         if ($urandom_range(9) == 0)
            send_byte(8'($urandom), $urandom_range(7) == 0);
         else
            send_random_mask();
         mask_count++;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (board.runs_due.size() != 0);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
src/scmrd_pkg.sv
src/skip_copy_mask_run_decoder.sv
tb/tb_top.sv
